>>> design/pwt_pkg.sv
// Shared codes and the result record for the protobuf wire tokenizer.
`timescale 1ns / 1ps

package pwt_pkg;

   // Result kinds
   localparam logic [2:0] KIND_VARINT  = 3'd0;
   localparam logic [2:0] KIND_FIX64   = 3'd1;
   localparam logic [2:0] KIND_LENHDR  = 3'd2;
   localparam logic [2:0] KIND_FIX32   = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;

   // Error codes
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_TAG    = 3'd1;
   localparam logic [2:0] ERR_VARINT = 3'd2;
   localparam logic [2:0] ERR_WIRE   = 3'd3;
   localparam logic [2:0] ERR_TRUNC  = 3'd4;

   // Supported wire types
   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_FIX64  = 3'd1;
   localparam logic [2:0] WIRE_LEN    = 3'd2;
   localparam logic [2:0] WIRE_FIX32  = 3'd5;

   // Byte limits of tags and varints, and byte counts of fixed fields
   localparam logic [3:0] TAG_MAX_BYTES    = 4'd5;
   localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
   localparam logic [3:0] FIX64_BYTES      = 4'd8;
   localparam logic [3:0] FIX32_BYTES      = 4'd4;

   // One token as produced by the decoder for one request
   typedef struct packed {
      logic        emit;
      logic [2:0]  kind;
      logic [31:0] field_number;
      logic [2:0]  wire_kind;
      logic [63:0] field_value;
      logic [7:0]  payload_byte;
      logic [2:0]  error_code;
      logic        last;
   } token_type;

endpackage

>>> design/protobuf_wire_tokenizer.sv
// Top level: request register, wire-format decoder and result register.
// A request is held in the request register, then passes through the decoder into the result register.
// Throughput: one request per cycle while results are taken; the decoder state updates in a single pass.
// A request in the input register moves on when the result register is free or drained.
// Reset (synchronous) empties both registers and returns the decoder to expecting a tag.
`timescale 1ns / 1ps

module protobuf_wire_tokenizer
   import pwt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_field_number,
   output logic [2:0]  rsp_wire_kind,
   output logic [63:0] rsp_field_value,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_message
);

   logic       in_valid_ff;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic       out_valid_ff;
   token_type  out_ff;
   token_type  token;
   logic       advance;

   // Move the held request through the decoder when the result slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_data_byte;
         end_ff  <= req_message_end;
      end
   end

   pwt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .data_byte   (byte_ff),
      .message_end (end_ff),
      .token       (token)
   );

   // Hold the result until taken; load a new one as it is produced
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && token.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && token.emit) begin
         out_ff <= token;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_ff.kind;
   assign rsp_field_number    = out_ff.field_number;
   assign rsp_wire_kind       = out_ff.wire_kind;
   assign rsp_field_value     = out_ff.field_value;
   assign rsp_payload_byte    = out_ff.payload_byte;
   assign rsp_error_code      = out_ff.error_code;
   assign rsp_last_of_message = out_ff.last;

   // An error code comes only with an error token
   a_err_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code and kind disagree");

   // Payload byte is zero outside payload tokens
   a_payload_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_PAYLOAD) |-> (rsp_payload_byte == 8'd0))
      else $error("payload byte set outside a payload token");

   // A request blocked in the input register stays put
   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(byte_ff) && $stable(end_ff)))
      else $error("blocked request lost or changed");

endmodule

>>> design/pwt_decode.sv
// Wire-format decode state and the per-byte next-state and token logic.
`timescale 1ns / 1ps

module pwt_decode
   import pwt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] data_byte,
   input  logic       message_end,
   output token_type  token
);

   typedef enum logic [2:0] {
      PH_TAG0,
      PH_TAGN,
      PH_VARINT,
      PH_FIX64,
      PH_LEN,
      PH_FIX32,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] field_ff, field_in;
   logic [2:0]  wire_ff, wire_in;
   logic [31:0] left_ff, left_in;
   logic        discard_ff, discard_in;

   logic        cont;
   logic [6:0]  low7;
   logic [3:0]  count_inc;
   logic [1:0]  tag_idx;
   logic [4:0]  tag_shift;
   logic [31:0] tag_part;
   logic [6:0]  var_shift;
   logic [63:0] var_part;
   logic [63:0] fix_part;
   logic [63:0] acc_sum;
   logic [31:0] left_dec;
   logic [3:0]  fix_need;
   logic        tag_done;
   logic [2:0]  err;

   assign cont      = data_byte[7];
   assign low7      = data_byte[6:0];
   assign count_inc = count_ff + 4'd1;

   // Place the next tag group: bit 4, 11, 18 or 25 of the field number
   assign tag_idx = 2'(count_ff - 4'd1);
   always_comb begin
      case (tag_idx)
         2'd0:    tag_shift = 5'd4;
         2'd1:    tag_shift = 5'd11;
         2'd2:    tag_shift = 5'd18;
         default: tag_shift = 5'd25;
      endcase
   end
   assign tag_part = 32'(low7) << tag_shift;

   // Varint groups land 7 bits apart; fixed bytes 8 bits apart
   assign var_shift = 7'(count_ff) * 7'd7;
   assign var_part  = 64'(low7) << var_shift;
   assign fix_part  = 64'(data_byte) << {count_ff[2:0], 3'b000};
   assign left_dec  = left_ff - 32'd1;

   // Next state and token for the byte at the decoder input
   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      field_in   = field_ff;
      wire_in    = wire_ff;
      left_in    = left_ff;
      discard_in = discard_ff;
      acc_sum    = acc_ff;
      fix_need   = FIX32_BYTES;
      tag_done   = 1'b0;
      err        = ERR_NONE;
      token      = '0;
      token.last = message_end;

      case (phase_ff)
         PH_TAG0: begin
            wire_in  = data_byte[2:0];
            field_in = 32'(data_byte[6:3]);
            if (cont) begin
               count_in = 4'd1;
               phase_in = PH_TAGN;
            end else begin
               tag_done = 1'b1;
            end
         end
         PH_TAGN: begin
            field_in = field_ff | tag_part;
            count_in = count_inc;
            if (!cont) begin
               tag_done = 1'b1;
            end else if (count_inc >= TAG_MAX_BYTES) begin
               err = ERR_TAG;
            end
         end
         PH_VARINT, PH_LEN: begin
            acc_sum  = acc_ff | var_part;
            acc_in   = acc_sum;
            count_in = count_inc;
            if (cont) begin
               if (count_inc >= VARINT_MAX_BYTES) err = ERR_VARINT;
            end else if (phase_ff == PH_VARINT) begin
               token.emit        = 1'b1;
               token.kind        = KIND_VARINT;
               token.field_value = acc_sum;
               phase_in          = PH_TAG0;
            end else if (acc_sum[31:0] != 32'd0 && message_end) begin
               err = ERR_TRUNC;
            end else begin
               token.emit        = 1'b1;
               token.kind        = KIND_LENHDR;
               token.field_value = 64'(acc_sum[31:0]);
               left_in           = acc_sum[31:0];
               phase_in          = (acc_sum[31:0] != 32'd0) ? PH_PAYLOAD : PH_TAG0;
            end
         end
         PH_FIX64, PH_FIX32: begin
            fix_need = (phase_ff == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES;
            acc_sum  = acc_ff | fix_part;
            acc_in   = acc_sum;
            count_in = count_inc;
            if (count_inc >= fix_need) begin
               token.emit        = 1'b1;
               token.kind        = (phase_ff == PH_FIX64) ? KIND_FIX64 : KIND_FIX32;
               token.field_value = acc_sum;
               phase_in          = PH_TAG0;
            end
         end
         PH_PAYLOAD: begin
            left_in = left_dec;
            if (left_dec != 32'd0 && message_end) begin
               err = ERR_TRUNC;
            end else begin
               token.emit         = 1'b1;
               token.kind         = KIND_PAYLOAD;
               token.payload_byte = data_byte;
               if (left_dec == 32'd0) phase_in = PH_TAG0;
            end
         end
         default: begin
            phase_in = PH_TAG0;
         end
      endcase

      // Check the wire type of a finished tag and start its value
      if (tag_done && err == ERR_NONE) begin
         if (wire_in inside {WIRE_VARINT, WIRE_FIX64, WIRE_LEN, WIRE_FIX32}) begin
            acc_in   = '0;
            count_in = '0;
            case (wire_in)
               WIRE_VARINT: phase_in = PH_VARINT;
               WIRE_FIX64:  phase_in = PH_FIX64;
               WIRE_LEN:    phase_in = PH_LEN;
               default:     phase_in = PH_FIX32;
            endcase
         end else begin
            err = ERR_WIRE;
         end
      end

      // Message ended inside a field
      if (err == ERR_NONE && message_end && phase_in != PH_TAG0) err = ERR_TRUNC;

      if (err != ERR_NONE) begin
         token            = '0;
         token.emit       = 1'b1;
         token.kind       = KIND_ERROR;
         token.error_code = err;
         token.last       = message_end;
         discard_in       = 1'b1;
      end
      token.field_number = field_in;
      token.wire_kind    = wire_in;

      // Drop everything while discarding
      if (discard_ff) begin
         phase_in   = phase_ff;
         acc_in     = acc_ff;
         count_in   = count_ff;
         field_in   = field_ff;
         wire_in    = wire_ff;
         left_in    = left_ff;
         token.emit = 1'b0;
      end

      // End of message always returns to expecting a tag
      if (message_end) begin
         phase_in   = PH_TAG0;
         acc_in     = '0;
         count_in   = '0;
         field_in   = '0;
         wire_in    = '0;
         left_in    = '0;
         discard_in = 1'b0;
      end
   end

   // Hold decode state; advance once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG0;
         acc_ff     <= '0;
         count_ff   <= '0;
         field_ff   <= '0;
         wire_ff    <= '0;
         left_ff    <= '0;
         discard_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         count_ff   <= count_in;
         field_ff   <= field_in;
         wire_ff    <= wire_in;
         left_ff    <= left_in;
         discard_ff <= discard_in;
      end
   end

endmodule
